// File: rtl/hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types, constants and conversion functions of the hopping RC packet
// receiver.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int HOP_CHANNELS_DEF = 16;

  localparam int SKIP_W   = 20;
  localparam int FAIL_W   = 24;
  localparam int CH_W     = 7;
  localparam int ADDR_W   = 16;
  localparam int STICK_W  = 16;
  localparam int EVENT_W  = 3;
  localparam int PKT_BYTES = 8;

  localparam logic [SKIP_W-1:0] SKIP_RESET = SKIP_W'(28000);
  localparam logic [FAIL_W-1:0] FAIL_RESET = FAIL_W'(1000000);

  localparam logic [7:0]      BIND_MARK    = 8'h20;
  localparam logic [CH_W-1:0] BIND_CHANNEL = CH_W'(22);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_SKIP = 1'b0,
    REG_FAIL = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_BIND     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_BAD      = 3'd2,
    EV_SKIP     = 3'd3,
    EV_FAILSAFE = 3'd4
  } event_t;

  typedef struct packed {
    logic [SKIP_W-1:0] skip_ticks;
    logic [FAIL_W-1:0] fail_ticks;
  } cfg_t;

  typedef struct packed {
    logic               failsafe;
    logic [2:0]         aux_changed;
    logic               fs_flag;
    logic               video_flag;
    logic               flip_flag;
    logic [STICK_W-1:0] yaw;
    logic [STICK_W-1:0] pitch;
    logic [STICK_W-1:0] roll;
    logic [STICK_W-1:0] throttle;
    logic [ADDR_W-1:0]  rx_address;
    logic [CH_W-1:0]    rf_channel;
  } result_t;

  localparam int RES_W   = $bits(result_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

  function automatic logic [6:0] hop_entry(input logic [3:0] idx);
    logic [6:0] ch;
    unique case (idx)
      4'd0, 4'd15: ch = 7'h02;
      4'd1, 4'd14: ch = 7'h48;
      4'd2, 4'd13: ch = 7'h0C;
      4'd3, 4'd12: ch = 7'h3E;
      4'd4, 4'd11: ch = 7'h16;
      4'd5, 4'd10: ch = 7'h34;
      4'd6, 4'd9:  ch = 7'h20;
      default:     ch = 7'h2A;
    endcase
    return ch;
  endfunction

  function automatic logic [STICK_W-1:0] throttle_q(input logic [7:0] b);
    logic signed [9:0]  d;
    logic signed [17:0] p;
    d = 10'sd225 - $signed({2'b00, b});
    p = 18'(d) * 18'sd74;
    return p[STICK_W-1:0];
  endfunction

  function automatic logic [STICK_W-1:0] stick_q(input logic [7:0] b, input logic neg);
    logic signed [9:0]  d;
    logic signed [17:0] p;
    d = neg ? (10'sd112 - $signed({2'b00, b})) : ($signed({2'b00, b}) - 10'sd112);
    p = 18'(d) * 18'sd146;
    return p[STICK_W-1:0];
  endfunction

endpackage

// File: rtl/hrc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_cfg_regs
// Register file for the skip and failsafe intervals behind a simple
// peripheral bus port.
// ----------------------------------------------------------------------------
module hrc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hrc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output hrc_pkg::cfg_t                   cfg
);
  import hrc_pkg::*;

  reg_idx_t sel;
  logic     wr;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_ticks <= SKIP_RESET;
      cfg.fail_ticks <= FAIL_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_SKIP: cfg.skip_ticks <= pwdata[SKIP_W-1:0];
        REG_FAIL: cfg.fail_ticks <= pwdata[FAIL_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_SKIP: prdata = CFG_DATA_W'(cfg.skip_ticks);
      REG_FAIL: prdata = CFG_DATA_W'(cfg.fail_ticks);
      default:  prdata = '0;
    endcase
  end

endmodule

// File: rtl/hrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_core
// Input register, receiver state update and result register. Each item is
// handled in one pass between the two registers.
// ----------------------------------------------------------------------------
module hrc_core #(
  parameter int HOP_CHANNELS = hrc_pkg::HOP_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hrc_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_type,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hrc_pkg::EVENT_W-1:0]      out_event,
  output hrc_pkg::result_t                 out_res
);
  import hrc_pkg::*;

  localparam int HOP_W = $clog2(HOP_CHANNELS);
  localparam int HIX_W = (HOP_W > 4) ? HOP_W : 4;
  localparam logic [HOP_W-1:0] HOP_LAST = HOP_W'(HOP_CHANNELS - 1);

  // Input register.
  logic       s1_valid;
  req_t       s1_type;
  logic [7:0] s1_byte;

  // Receiver state.
  logic              bound, bound_next;
  logic [3:0]        byte_index, byte_index_next;
  logic [7:0]        pkt [PKT_BYTES];
  logic [7:0]        byte_sum, byte_sum_next;
  logic [HOP_W-1:0]  hop_index, hop_index_next;
  logic [2:0]        hop_offset, hop_offset_next;
  logic [7:0]        sum_seed, sum_seed_next;
  logic [ADDR_W-1:0] address_bytes, address_bytes_next;
  logic [FAIL_W-1:0] ticks_good, ticks_good_next;
  logic [SKIP_W-1:0] ticks_hop, ticks_hop_next;
  logic              failsafe_on, failsafe_on_next;
  logic [2:0]        last_flags, last_flags_next;

  logic              res_valid;
  event_t            res_event;
  logic              good;
  logic              pkt_write;
  logic [FAIL_W-1:0] tg_inc;
  logic [SKIP_W-1:0] th_inc;
  logic              skip_hit, fail_hit;
  logic [HOP_W-1:0]  hop_step;
  logic [HIX_W-1:0]  hop_ext;
  logic [2:0]        flags;
  logic              out_free, advance;
  result_t           res;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (!res_valid || out_free);
  assign in_ready = !s1_valid || advance;

  assign hop_step = (hop_index == HOP_LAST) ? '0 : hop_index + 1'b1;
  assign tg_inc   = (ticks_good == '1) ? ticks_good : ticks_good + 1'b1;
  assign th_inc   = (ticks_hop == '1) ? ticks_hop : ticks_hop + 1'b1;
  assign skip_hit = bound && (th_inc > cfg.skip_ticks);
  assign fail_hit = tg_inc > cfg.fail_ticks;
  assign flags    = {pkt[6][0], pkt[6][4], pkt[6][7]};

  always_comb begin
    bound_next         = bound;
    byte_index_next    = byte_index;
    byte_sum_next      = byte_sum;
    hop_index_next     = hop_index;
    hop_offset_next    = hop_offset;
    sum_seed_next      = sum_seed;
    address_bytes_next = address_bytes;
    ticks_good_next    = ticks_good;
    ticks_hop_next     = ticks_hop;
    failsafe_on_next   = failsafe_on;
    last_flags_next    = last_flags;
    res_valid          = 1'b0;
    res_event          = EV_BAD;
    good               = 1'b0;
    pkt_write          = 1'b0;
    if (s1_type == REQ_TICK) begin
      ticks_good_next  = tg_inc;
      ticks_hop_next   = skip_hit ? '0 : th_inc;
      hop_index_next   = skip_hit ? hop_step : hop_index;
      failsafe_on_next = failsafe_on || fail_hit;
      res_valid        = skip_hit || (fail_hit && !failsafe_on);
      res_event        = (fail_hit && !failsafe_on) ? EV_FAILSAFE : EV_SKIP;
    end else if (!byte_index[3]) begin
      pkt_write       = 1'b1;
      byte_sum_next   = byte_sum + s1_byte;
      byte_index_next = byte_index + 1'b1;
    end else begin
      byte_index_next = '0;
      byte_sum_next   = '0;
      res_valid       = 1'b1;
      if (!bound) begin
        if (pkt[0] == BIND_MARK) begin
          address_bytes_next = {pkt[4], pkt[5]};
          hop_offset_next    = pkt[7][6:4] + pkt[7][2:0];
          sum_seed_next      = pkt[7];
          bound_next         = 1'b1;
          hop_index_next     = hop_step;
          res_event          = EV_BIND;
        end
      end else if (8'(byte_sum + sum_seed) == s1_byte) begin
        good             = 1'b1;
        last_flags_next  = flags;
        ticks_good_next  = '0;
        ticks_hop_next   = '0;
        failsafe_on_next = 1'b0;
        hop_index_next   = hop_step;
        res_event        = EV_GOOD;
      end
    end
  end

  assign hop_ext = HIX_W'(hop_index_next);

  always_comb begin
    res.rf_channel  = bound_next ? hop_entry(hop_ext[3:0]) + CH_W'(hop_offset_next)
                                 : BIND_CHANNEL;
    res.rx_address  = address_bytes_next;
    res.throttle    = good ? throttle_q(pkt[0]) : '0;
    res.roll        = good ? stick_q(pkt[2], 1'b0) : '0;
    res.pitch       = good ? stick_q(pkt[3], 1'b0) : '0;
    res.yaw         = good ? stick_q(pkt[1], 1'b1) : '0;
    res.flip_flag   = last_flags_next[0];
    res.video_flag  = last_flags_next[1];
    res.fs_flag     = last_flags_next[2];
    res.aux_changed = good ? (flags ^ last_flags) : '0;
    res.failsafe    = failsafe_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      bound         <= 1'b0;
      byte_index    <= '0;
      byte_sum      <= '0;
      hop_index     <= '0;
      hop_offset    <= '0;
      sum_seed      <= '0;
      address_bytes <= '0;
      ticks_good    <= '0;
      ticks_hop     <= '0;
      failsafe_on   <= 1'b0;
      last_flags    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        bound         <= bound_next;
        byte_index    <= byte_index_next;
        byte_sum      <= byte_sum_next;
        hop_index     <= hop_index_next;
        hop_offset    <= hop_offset_next;
        sum_seed      <= sum_seed_next;
        address_bytes <= address_bytes_next;
        ticks_good    <= ticks_good_next;
        ticks_hop     <= ticks_hop_next;
        failsafe_on   <= failsafe_on_next;
        last_flags    <= last_flags_next;
      end
      if (out_free) begin
        out_valid <= advance && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_type <= req_t'(in_type);
      s1_byte <= in_byte;
    end
    if (advance && pkt_write) begin
      pkt[byte_index[2:0]] <= s1_byte;
    end
    if (out_free && advance && res_valid) begin
      out_event <= res_event;
      out_res   <= res;
    end
  end

endmodule

// File: rtl/hopping_rc_packet_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopping_rc_packet_receiver_top
// Frequency-hopping radio-control packet receiver with bind, checksum check,
// stick conversion, channel skip and failsafe.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, and the result that it
// causes is presented from the result register.
// Throughput: one item per cycle; a new item still enters while a result waits
// on the output unless the item in the input register also yields a result.
// Reset: synchronous rst returns all state to bind mode, clears both tick
// counters and failsafe, and loads the interval registers with their defaults.
module hopping_rc_packet_receiver_top #(
  parameter int HOP_CHANNELS = hrc_pkg::HOP_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // rf_channel, rx_address, throttle, roll, pitch, yaw, flip_flag,
  // video_flag, fs_flag, aux_changed, failsafe, zero fill
  output logic [hrc_pkg::TDATA_W-1:0]     m_tdata,
  output logic [hrc_pkg::EVENT_W-1:0]     m_tuser,   // event_res
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [hrc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import hrc_pkg::*;

  cfg_t    cfg;
  result_t res;

  hrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrc_core #(
    .HOP_CHANNELS (HOP_CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_type   (s_tuser),
    .in_byte   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_event (m_tuser),
    .out_res   (res)
  );

  assign m_tdata = TDATA_W'(res);

endmodule

// File: rtl/hrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_port_checker
// Port-level checks of the receiver result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hrc_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [hrc_pkg::TDATA_W-1:0] m_tdata,
  input logic [hrc_pkg::EVENT_W-1:0] m_tuser
);
  import hrc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_sticks_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != EV_GOOD |-> m_tdata[86:23] == '0 && m_tdata[92:90] == '0)
    else $error("sticks or change mask set outside a good packet");

  a_fs_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_FAILSAFE |-> m_tdata[93])
    else $error("failsafe event without failsafe flag");

  a_good_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_GOOD |-> !m_tdata[93])
    else $error("good packet left failsafe set");

endmodule

bind hopping_rc_packet_receiver_top hrc_port_checker u_hrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: sim/hrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_checker
// Watches the configuration port and both streams of the hopping RC packet
// receiver, keeps its own model of bind state, hopping, tick counters and
// failsafe, and compares every report on the output stream field by field.
// ----------------------------------------------------------------------------
module hrc_checker #(
  parameter int HOP_CHANNELS = hrc_pkg::HOP_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tuser,   // req_type
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // rf_channel, rx_address, throttle, roll, pitch, yaw, flip_flag,
  // video_flag, fs_flag, aux_changed, failsafe, zero fill
  input  logic [hrc_pkg::TDATA_W-1:0]     m_tdata,
  input  logic [hrc_pkg::EVENT_W-1:0]     m_tuser,   // event_res
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [hrc_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic                            pready,
  output int                              fails,
  output int                              pending
);
  import hrc_pkg::*;

  typedef struct packed {
    event_t  ev;
    result_t res;
  } link_report_t;

  localparam logic [0:15][6:0] HOP_TAB = {
    7'h02, 7'h48, 7'h0C, 7'h3E, 7'h16, 7'h34, 7'h20, 7'h2A,
    7'h2A, 7'h20, 7'h34, 7'h16, 7'h3E, 7'h0C, 7'h48, 7'h02
  };

  logic              bound;
  logic [3:0]        byte_idx;
  logic [7:0]        pkt [8];
  logic [7:0]        sum_acc;
  int                hop_idx;
  logic [2:0]        hop_off;
  logic [7:0]        seed;
  logic [15:0]       addr;
  logic [FAIL_W-1:0] since_good;
  logic [SKIP_W-1:0] since_hop;
  logic              fs_on;
  logic [2:0]        last_flags;
  logic [SKIP_W-1:0] skip_lim;
  logic [FAIL_W-1:0] fail_lim;
  link_report_t      link_reports [$];
  int                err_cnt;

  initial begin
    fails = 0;
    pending = 0;
    err_cnt = 0;
  end

  function automatic int next_hop(input int idx);
    return (idx + 1 >= HOP_CHANNELS) ? 0 : idx + 1;
  endfunction

  function automatic link_report_t make_report(input event_t ev);
    link_report_t rep;
    rep = '0;
    rep.ev = ev;
    rep.res.rf_channel = bound ? 7'(HOP_TAB[hop_idx % 16] + hop_off) : BIND_CHANNEL;
    rep.res.rx_address = addr;
    rep.res.flip_flag = last_flags[0];
    rep.res.video_flag = last_flags[1];
    rep.res.fs_flag = last_flags[2];
    rep.res.failsafe = fs_on;
    return rep;
  endfunction

  task automatic link_step(input req_t kind, input logic [7:0] b);
    bit           entered;
    bit           skipped;
    logic [7:0]   chk;
    logic [7:0]   f;
    logic [2:0]   flags;
    logic [2:0]   changed;
    int           thr;
    int           rol;
    int           pit;
    int           yw;
    link_report_t rep;
    entered = 0;
    skipped = 0;
    if (kind == REQ_TICK) begin
      if (since_good != '1) since_good = since_good + 1;
      if (since_hop != '1) since_hop = since_hop + 1;
      if (bound && since_hop > skip_lim) begin
        hop_idx = next_hop(hop_idx);
        since_hop = '0;
        skipped = 1;
      end
      if (since_good > fail_lim) begin
        entered = !fs_on;
        fs_on = 1'b1;
      end
      if (entered) link_reports.push_back(make_report(EV_FAILSAFE));
      else if (skipped) link_reports.push_back(make_report(EV_SKIP));
    end else if (byte_idx < 4'd8) begin
      pkt[byte_idx[2:0]] = b;
      sum_acc = sum_acc + b;
      byte_idx = byte_idx + 1;
    end else begin
      chk = sum_acc + seed;
      byte_idx = '0;
      sum_acc = '0;
      if (!bound) begin
        if (pkt[0] == BIND_MARK) begin
          addr = {pkt[4], pkt[5]};
          hop_off = 3'(pkt[7][7:4] + pkt[7][3:0]);
          seed = pkt[7];
          bound = 1'b1;
          hop_idx = next_hop(hop_idx);
          link_reports.push_back(make_report(EV_BIND));
        end else begin
          link_reports.push_back(make_report(EV_BAD));
        end
      end else if (chk != b) begin
        link_reports.push_back(make_report(EV_BAD));
      end else begin
        thr = (225 - int'(pkt[0])) * 74;
        rol = (int'(pkt[2]) - 112) * 146;
        pit = (int'(pkt[3]) - 112) * 146;
        yw = (112 - int'(pkt[1])) * 146;
        f = pkt[6];
        flags = {f[0], f[4], f[7]};
        changed = flags ^ last_flags;
        last_flags = flags;
        since_good = '0;
        since_hop = '0;
        fs_on = 1'b0;
        hop_idx = next_hop(hop_idx);
        rep = make_report(EV_GOOD);
        rep.res.aux_changed = changed;
        rep.res.throttle = 16'(thr);
        rep.res.roll = 16'(rol);
        rep.res.pitch = 16'(pit);
        rep.res.yaw = 16'(yw);
        link_reports.push_back(rep);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    link_report_t w;
    result_t      got;
    if (rst) begin
      bound = 1'b0;
      byte_idx = '0;
      for (int i = 0; i < 8; i++) pkt[i] = '0;
      sum_acc = '0;
      hop_idx = 0;
      hop_off = '0;
      seed = '0;
      addr = '0;
      since_good = '0;
      since_hop = '0;
      fs_on = 1'b0;
      last_flags = '0;
      skip_lim = SKIP_RESET;
      fail_lim = FAIL_RESET;
      link_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_SKIP: skip_lim = pwdata[SKIP_W-1:0];
          REG_FAIL: fail_lim = pwdata[FAIL_W-1:0];
        endcase
      end
      if (s_tvalid && s_tready) link_step(req_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        if (link_reports.size() == 0) begin
          $display("%0t ns: report with no item waiting, expected none, actual event %0d data %h",
                   $time, m_tuser, m_tdata);
          err_cnt++;
        end else begin
          w = link_reports.pop_front();
          got = result_t'(m_tdata[RES_W-1:0]);
          check_field("event_res", 16'(w.ev), 16'(m_tuser));
          check_field("rf_channel", 16'(w.res.rf_channel), 16'(got.rf_channel));
          check_field("rx_address", w.res.rx_address, got.rx_address);
          check_field("throttle", w.res.throttle, got.throttle);
          check_field("roll", w.res.roll, got.roll);
          check_field("pitch", w.res.pitch, got.pitch);
          check_field("yaw", w.res.yaw, got.yaw);
          check_field("flip_flag", 16'(w.res.flip_flag), 16'(got.flip_flag));
          check_field("video_flag", 16'(w.res.video_flag), 16'(got.video_flag));
          check_field("fs_flag", 16'(w.res.fs_flag), 16'(got.fs_flag));
          check_field("aux_changed", 16'(w.res.aux_changed), 16'(got.aux_changed));
          check_field("failsafe", 16'(w.res.failsafe), 16'(got.failsafe));
          check_field("zero fill", 16'h0000, 16'(m_tdata >> RES_W));
        end
      end
    end
    fails <= err_cnt;
    pending <= link_reports.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the hopping RC packet receiver with bind, good and damaged packets,
// stray bytes and tick runs under several interval settings, with bursty
// input, a stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import hrc_pkg::*;

  typedef logic [8:0][7:0] frame_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic [EVENT_W-1:0]    m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fails;
  int                    pending;

  int         idle_cycles = 0;
  int         burst_left = 0;
  int         items_sent = 0;
  int         byte_pos = 0;
  logic [7:0] seed_byte = '0;
  logic       hold_tog = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         rx_mode = 0;
  int         rx_left = 0;

  hopping_rc_packet_receiver_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  hrc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(10, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("hopping_rc_packet_receiver_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(input req_t kind, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (kind == REQ_BYTE) byte_pos = (byte_pos == 8) ? 0 : byte_pos + 1;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(REQ_TICK, 8'($urandom));
  endtask

  // Stray bytes left from a broken packet are completed first, so the frame
  // starts at byte 0. Ticks may fall between the bytes of a packet.
  task automatic send_frame(input frame_t f, input bit ticks_between);
    while (byte_pos != 0) send(REQ_BYTE, 8'($urandom));
    for (int i = 0; i < 9; i++) begin
      if (ticks_between && $urandom_range(0, 7) == 0) send_ticks($urandom_range(1, 3));
      send(REQ_BYTE, f[i]);
    end
  endtask

  function automatic logic [7:0] check_byte(input frame_t f);
    logic [7:0] s;
    s = seed_byte;
    for (int i = 0; i < 8; i++) s = s + f[i];
    return s;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int i = 0; i < 9; i++) f[i] = 8'($urandom);
    return f;
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    frame_t      f;
    int          pick;
    int          target;
    logic [31:0] skip_val;
    logic [31:0] fail_val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_write(REG_SKIP, 32'd1);
    apb_write(REG_FAIL, 32'd2);

    // Failsafe raised while unbound, then a tick with failsafe already on.
    send_ticks(4);
    f = '1;
    send_frame(f, 0);
    f = '0;
    f[0] = BIND_MARK;
    f[4] = 8'hFF;
    f[6] = 8'hFF;
    f[7] = 8'hFF;
    send_frame(f, 0);
    seed_byte = f[7];
    send_ticks(1);
    f = rand_frame();
    f[0] = 8'h00;
    f[1] = 8'hFF;
    f[2] = 8'h00;
    f[3] = 8'hFF;
    f[6] = 8'h91;
    f[8] = check_byte(f);
    send_frame(f, 0);
    f = rand_frame();
    f[0] = 8'hFF;
    f[1] = 8'h00;
    f[2] = 8'hFF;
    f[3] = 8'h00;
    f[6] = 8'h6E;
    f[8] = check_byte(f);
    send_frame(f, 0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          skip_val = 32'h000F_FFFF;
          fail_val = 32'h00FF_FFFF;
        end
        1: begin
          skip_val = 32'd1;
          fail_val = 32'd1;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: skip_val = 32'd1;
            1: skip_val = 32'h000F_FFFF;
            2, 3: skip_val = $urandom_range(2, 40);
            default: skip_val = $urandom_range(41, 400);
          endcase
          case ($urandom_range(0, 5))
            0: fail_val = 32'd1;
            1: fail_val = 32'h00FF_FFFF;
            2, 3: fail_val = $urandom_range(2, 60);
            default: fail_val = $urandom_range(61, 600);
          endcase
        end
      endcase
      apb_write(REG_SKIP, skip_val);
      apb_write(REG_FAIL, fail_val);
      if (p == 1) begin
        hold_tog <= ~hold_tog;
        send_ticks(80);
      end
      target = items_sent + 110;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        f = rand_frame();
        if (pick < 8) f[0] = BIND_MARK;
        if (pick < 60) begin
          f[8] = check_byte(f);
          send_frame(f, 1);
        end else if (pick < 75) begin
          f[8] = check_byte(f) + 8'($urandom_range(1, 255));
          send_frame(f, 1);
        end else if (pick < 90) begin
          send_ticks($urandom_range(1, 30));
        end else begin
          repeat ($urandom_range(1, 8)) send(REQ_BYTE, 8'($urandom));
        end
      end
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("hopping_rc_packet_receiver_top: match");
    end else begin
      $display("hopping_rc_packet_receiver_top: mismatch");
    end
    $finish;
  end

endmodule
